[rtl/acrms_pkg.sv]
// Shared constants for the AC RMS window accumulator.
`timescale 1ns / 1ps
package acrms_pkg;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int RMS_BITS        = 20;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    // classified operation handed from front to back
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;
endpackage

[rtl/ac_rms_window_accumulator.sv]
// Top level of the AC RMS window accumulator.
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_stall  | func, sample, sample_valid
//  out     | output    | o_valid / i_stall  | rms_value, result_valid, counts, overflow
// Start and sample words pass through the queue and then the accumulator.
// An end word on an open, non-empty window runs a multi-cycle job: digit products for
// N*Q and S*S, the variance, one root bit per cycle, then one quotient bit per cycle,
// and then the result word.
// Reset is synchronous and clears the window state; no clearing pass.
// A four-entry queue keeps taking words, until it is full, while the back end computes or the output stalls.
`timescale 1ns / 1ps
module ac_rms_window_accumulator #(
    parameter int SAMPLE_BITS = acrms_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = acrms_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = acrms_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [11:0] i_sample,
    input  logic        i_sample_valid,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [19:0] o_rms_value,
    output logic        o_result_valid,
    output logic [23:0] o_total_samples,
    output logic [23:0] o_unique_samples,
    output logic        o_overflow
);
    logic q_valid, q_pop, q_ok;
    logic [1:0] q_op;
    logic [SAMPLE_BITS-1:0] q_sample;

    acrms_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_sample, .i_sample_valid,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_op(q_op),
        .o_q_sample(q_sample), .o_q_ok(q_ok)
    );

    acrms_back #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS),
                 .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_op(q_op),
        .i_q_sample(q_sample), .i_q_ok(q_ok), .o_valid, .i_stall, .o_rms_value,
        .o_result_valid, .o_total_samples, .o_unique_samples, .o_overflow
    );
endmodule

[rtl/acrms_front.sv]
// Front end: accept input words, drop those that cannot matter, queue the rest.
`timescale 1ns / 1ps
module acrms_front #(
    parameter int SAMPLE_BITS = acrms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_func,
    input  logic [11:0]            i_sample,
    input  logic                   i_sample_valid,
    output logic                   o_q_valid,
    input  logic                   i_q_pop,
    output logic [1:0]             o_q_op,
    output logic [SAMPLE_BITS-1:0] o_q_sample,
    output logic                   o_q_ok
);
    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    logic [1:0]             r_op  [DEPTH];
    logic [SAMPLE_BITS-1:0] r_smp [DEPTH];
    logic                   r_ok  [DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [PW:0]   r_cnt, n_cnt;
    logic          push, keep;
    logic [SAMPLE_BITS-1:0] smp_w;

    // keep only the bits of the 12-bit code that the sample width allows
    always_comb begin
        smp_w = '0;
        for (int b = 0; b < SAMPLE_BITS; b++) begin
            if (b < 12) smp_w[b] = i_sample[b];
        end
    end

    assign o_stall = (r_cnt == (PW+1)'(DEPTH));
    // unused code three carries no work; invalid samples carry none either
    assign keep = (i_func == acrms_pkg::FUNC_START) || (i_func == acrms_pkg::FUNC_END) ||
                  (i_func == acrms_pkg::FUNC_SAMPLE && i_sample_valid);
    assign push = i_valid && !o_stall && keep;

    assign o_q_valid  = (r_cnt != '0);
    assign o_q_op     = r_op[r_rp];
    assign o_q_sample = r_smp[r_rp];
    assign o_q_ok     = r_ok[r_rp];

    always_comb begin
        n_wp  = r_wp + PW'(push);
        n_rp  = r_rp + PW'(i_q_pop);
        n_cnt = r_cnt + (PW+1)'(push) - (PW+1)'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wp]  <= i_func;
            r_smp[r_wp] <= smp_w;
            r_ok[r_wp]  <= i_sample_valid;
        end
    end
endmodule

[rtl/acrms_back.sv]
// Back end: window accumulation and the end-of-window variance, root and divide.
`timescale 1ns / 1ps
module acrms_back #(
    parameter int SAMPLE_BITS = acrms_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = acrms_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = acrms_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  logic [1:0]             i_q_op,
    input  logic [SAMPLE_BITS-1:0] i_q_sample,
    input  logic                   i_q_ok,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [19:0]            o_rms_value,
    output logic                   o_result_valid,
    output logic [23:0]            o_total_samples,
    output logic [23:0]            o_unique_samples,
    output logic                   o_overflow
);
    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_BITS  = 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int PR_BITS  = SQ_BITS + COUNT_BITS;          // N*Q
    localparam int D_BITS   = PR_BITS + 2 * FRAC_BITS;       // shifted variance
    localparam int RT_BITS  = (D_BITS + 1) / 2;              // root width
    localparam int RD_BITS  = RT_BITS + 2;
    localparam int PAIRS    = RT_BITS;
    localparam int PC_BITS  = $clog2(PAIRS + 1);
    localparam int DC_BITS  = $clog2(RT_BITS + 1);
    localparam int MW       = 16;                            // multiplier digit
    localparam int NQ_DIG   = (SQ_BITS + MW - 1) / MW;
    localparam int SS_DIG   = (SUM_BITS + MW - 1) / MW;
    localparam int DG_BITS  = $clog2(NQ_DIG + SS_DIG + 1);
    localparam int QW       = NQ_DIG * MW;
    localparam int SW       = SS_DIG * MW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NQ   = 3'd1;
    localparam logic [2:0] ST_SS   = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_VAR  = 3'd6;

    logic [2:0] r_st, n_st;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic r_have, r_active, r_sat;
    logic [COUNT_BITS-1:0] r_vcnt, r_dcnt;
    logic [SUM_BITS-1:0] r_sum;
    logic [SQ_BITS-1:0]  r_sq;

    logic [PR_BITS-1:0]  r_nq;
    logic [PR_BITS-1:0]  r_ss;
    logic [DG_BITS-1:0]  r_dig;
    logic [D_BITS-1:0]   r_d;
    logic [RD_BITS-1:0]  r_rem;
    logic [RT_BITS-1:0]  r_root;
    logic [PC_BITS-1:0]  r_pc;
    logic [RT_BITS-1:0]  r_quo;
    logic [COUNT_BITS:0] r_drem;
    logic [DC_BITS-1:0]  r_dc;

    logic r_ovalid;
    logic [19:0] r_orms;
    logic r_ores, r_oovf;
    logic [23:0] r_otot, r_ouni;

    logic [COUNT_BITS:0]   vc_inc, dc_inc;
    logic [SUM_BITS:0]     sum_add;
    logic [SQ_BITS:0]      sq_add;
    logic [2*SAMPLE_BITS-1:0] smp_sq;
    logic is_dup;
    logic sat_hit;
    logic out_load;
    logic [QW-1:0] q_ext;
    logic [SW-1:0] s_ext;
    logic [MW-1:0] q_dig, s_dig;
    logic [MW+COUNT_BITS-1:0] nq_part;
    logic [MW+SUM_BITS-1:0]   ss_part;
    logic [RD_BITS-1:0] trial, rem_sh;
    logic [COUNT_BITS:0] dsh;
    logic [RT_BITS-1:0] root_bit;

    assign o_q_pop = i_q_valid && (r_st == ST_IDLE);

    assign smp_sq  = i_q_sample * i_q_sample;
    assign is_dup  = r_have && (r_prev == i_q_sample);
    assign vc_inc  = {1'b0, r_vcnt} + (COUNT_BITS+1)'(1);
    assign dc_inc  = {1'b0, r_dcnt} + (COUNT_BITS+1)'(1);
    assign sum_add = {1'b0, r_sum} + (SUM_BITS+1)'(i_q_sample);
    assign sq_add  = {1'b0, r_sq} + (SQ_BITS+1)'(smp_sq);
    assign sat_hit = vc_inc[COUNT_BITS] ||
                     (!is_dup && (dc_inc[COUNT_BITS] || sum_add[SUM_BITS] || sq_add[SQ_BITS]));
    // load the output register once the previous word has gone
    assign out_load = (r_st == ST_OUT) && (!r_ovalid || !i_stall);

    assign q_ext = QW'(r_sq);
    assign s_ext = SW'(r_sum);
    always_comb begin
        q_dig = '0; s_dig = '0;
        for (int k = 0; k < NQ_DIG; k++)
            if (DG_BITS'(k) == r_dig) q_dig = q_ext[k*MW +: MW];
        for (int k = 0; k < SS_DIG; k++)
            if (DG_BITS'(k + NQ_DIG) == r_dig) s_dig = s_ext[k*MW +: MW];
    end
    assign nq_part = q_dig * r_dcnt;
    assign ss_part = s_dig * r_sum;

    // restoring square root, one bit pair per cycle
    assign rem_sh = {r_rem[RD_BITS-3:0], r_d[D_BITS-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign dsh    = {r_drem[COUNT_BITS-1:0], root_bit[RT_BITS-1]};
    assign root_bit = r_root << r_dc;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (o_q_pop && i_q_op == acrms_pkg::OP_END && r_active)
                         n_st = (r_dcnt == '0) ? ST_OUT : ST_NQ;
            ST_NQ:   if (r_dig == DG_BITS'(NQ_DIG - 1)) n_st = ST_SS;
            ST_SS:   if (r_dig == DG_BITS'(NQ_DIG + SS_DIG - 1)) n_st = ST_VAR;
            ST_VAR:  n_st = ST_SQRT;
            ST_SQRT: if (r_pc == PC_BITS'(PAIRS - 1)) n_st = ST_DIV;
            ST_DIV:  if (r_dc == DC_BITS'(RT_BITS - 1)) n_st = ST_OUT;
            ST_OUT:  if (out_load) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_have <= 1'b0; r_active <= 1'b0; r_sat <= 1'b0;
            r_prev <= '0; r_vcnt <= '0; r_dcnt <= '0; r_sum <= '0; r_sq <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (o_q_pop) begin
                unique case (i_q_op)
                    acrms_pkg::OP_START: begin
                        r_vcnt <= '0; r_dcnt <= '0; r_sum <= '0; r_sq <= '0;
                        r_sat <= 1'b0; r_active <= 1'b1;
                        r_have <= i_q_ok;
                        r_prev <= i_q_ok ? i_q_sample : '0;
                    end
                    acrms_pkg::OP_SAMPLE: if (r_active) begin
                        if (sat_hit) r_sat <= 1'b1;
                        if (!vc_inc[COUNT_BITS]) r_vcnt <= vc_inc[COUNT_BITS-1:0];
                        if (!is_dup) begin
                            r_prev <= i_q_sample; r_have <= 1'b1;
                            if (!dc_inc[COUNT_BITS]) r_dcnt <= dc_inc[COUNT_BITS-1:0];
                            r_sum <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
                            r_sq  <= sq_add[SQ_BITS] ? '1 : sq_add[SQ_BITS-1:0];
                        end
                    end
                    default: if (r_active) r_active <= 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_dig <= '0; r_nq <= '0; r_ss <= '0; r_pc <= '0; r_dc <= '0;
                r_rem <= '0; r_root <= '0; r_quo <= '0; r_drem <= '0;
            end
            ST_NQ: begin
                r_nq  <= r_nq + (PR_BITS'(nq_part) << (MW * r_dig));
                r_dig <= r_dig + DG_BITS'(1);
            end
            ST_SS: begin
                r_ss  <= r_ss + (PR_BITS'(ss_part) << (MW * (r_dig - DG_BITS'(NQ_DIG))));
                r_dig <= r_dig + DG_BITS'(1);
            end
            // variance clamped at zero, latched once both products are complete
            ST_VAR: begin
                r_d <= (r_nq >= r_ss) ? (D_BITS'(r_nq - r_ss) << (2 * FRAC_BITS)) : '0;
            end
            ST_SQRT: begin
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[RT_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[RT_BITS-2:0], 1'b0};
                end
                r_d  <= r_d << 2;
                r_pc <= r_pc + PC_BITS'(1);
            end
            ST_DIV: begin
                if (dsh >= {1'b0, r_dcnt}) begin
                    r_drem <= dsh - {1'b0, r_dcnt};
                    r_quo  <= {r_quo[RT_BITS-2:0], 1'b1};
                end else begin
                    r_drem <= dsh;
                    r_quo  <= {r_quo[RT_BITS-2:0], 1'b0};
                end
                r_dc <= r_dc + DC_BITS'(1);
            end
            default: ;
        endcase
        if (out_load) begin
            r_orms <= (r_dcnt == '0) ? '0 :
                      ((RT_BITS > 20 && (r_quo >> 20) != '0) ? '1 : 20'(r_quo));
            r_ores <= (r_dcnt != '0);
            r_otot <= 24'(r_vcnt);
            r_ouni <= 24'(r_dcnt);
            r_oovf <= r_sat;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_rms_value      = r_orms;
    assign o_result_valid   = r_ores;
    assign o_total_samples  = r_otot;
    assign o_unique_samples = r_ouni;
    assign o_overflow       = r_oovf;
endmodule

[rtl/acrms_checker.sv]
// Port-level checks for the AC RMS window accumulator.
`timescale 1ns / 1ps
module acrms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [19:0] o_rms_value,
    input logic        o_result_valid,
    input logic [23:0] o_total_samples,
    input logic [23:0] o_unique_samples
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rms_value))
        else $error("stalled result word changed");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result_valid |-> o_rms_value == 20'd0 && o_unique_samples == 24'd0)
        else $error("empty window gave a value");
    a_uniq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_unique_samples <= o_total_samples)
        else $error("unique count above total");
    a_resv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unique_samples != 24'd0 |-> o_result_valid)
        else $error("result flag wrong");
endmodule

bind ac_rms_window_accumulator acrms_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_rms_value, .o_result_valid,
    .o_total_samples, .o_unique_samples
);

[verif/tb_ac_rms_window_accumulator.sv]
// Self-checking testbench for the AC RMS window accumulator: directed table, random windows.
`timescale 1ns / 1ps
module tb_ac_rms_window_accumulator;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         DIR_ROWS    = 23;

    typedef struct packed {
        logic [19:0] rms;
        logic        rv;
        logic [23:0] total;
        logic [23:0] uniq;
        logic        ovf;
    } t_rms_result;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] sample;
        logic        ok;
        logic        typed;
        t_rms_result res;
    } t_dir_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_func = acrms_pkg::FUNC_START;
    logic [11:0] i_sample = '0;
    logic        i_sample_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [19:0] o_rms_value;
    logic        o_result_valid;
    logic [23:0] o_total_samples;
    logic [23:0] o_unique_samples;
    logic        o_overflow;

    ac_rms_window_accumulator uut (.*);

    // window state of the predictor
    logic [11:0] last_code;
    logic        last_held;
    logic        window_open;
    logic [23:0] valid_cnt;
    logic [23:0] unique_cnt;
    logic [35:0] code_sum;
    logic [47:0] square_sum;
    logic        sat_seen;

    t_rms_result pending_rms[$];
    int          errors = 0;
    bit          no_idle = 1'b0;
    int          hold_req = 0;
    t_dir_word   dir_tab[DIR_ROWS];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb_ac_rms_window_accumulator failed");
        $finish;
    end

    function automatic logic [127:0] floor_root(logic [127:0] v);
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] trial;
        rem = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
            trial = (root << 2) | 128'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 128'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // advance the window by one accepted word; returns 1 when a result falls out
    function automatic bit window_step(logic [1:0] f, logic [11:0] s, logic ok,
                                       output t_rms_result r);
        logic [127:0] nq;
        logic [127:0] ss;
        logic [127:0] q;
        r = '0;
        case (f)
            acrms_pkg::FUNC_START: begin
                valid_cnt = '0;
                unique_cnt = '0;
                code_sum = '0;
                square_sum = '0;
                sat_seen = 1'b0;
                window_open = 1'b1;
                last_held = ok;
                last_code = ok ? s : '0;
            end
            acrms_pkg::FUNC_SAMPLE: begin
                if (window_open && ok) begin
                    if (&valid_cnt) sat_seen = 1'b1; else valid_cnt++;
                    if (!(last_held && last_code == s)) begin
                        if (&unique_cnt) sat_seen = 1'b1; else unique_cnt++;
                        last_code = s;
                        last_held = 1'b1;
                        if ({1'b0, code_sum} + s > 37'h0_FFFF_FFFFF) begin
                            code_sum = '1;
                            sat_seen = 1'b1;
                        end else begin
                            code_sum = code_sum + s;
                        end
                        if ({1'b0, square_sum} + 49'(s) * 49'(s) >
                            49'h0_FFFF_FFFF_FFFF) begin
                            square_sum = '1;
                            sat_seen = 1'b1;
                        end else begin
                            square_sum = square_sum + 48'(s) * 48'(s);
                        end
                    end
                end
            end
            acrms_pkg::FUNC_END: begin
                if (window_open) begin
                    window_open = 1'b0;
                    if (unique_cnt != 0) begin
                        nq = 128'(unique_cnt) * 128'(square_sum);
                        ss = 128'(code_sum) * 128'(code_sum);
                        q = (nq >= ss) ? nq - ss : '0;
                        q = floor_root(q << 16) / 128'(unique_cnt);
                        r.rms = (q > 128'hF_FFFF) ? 20'hF_FFFF : q[19:0];
                        r.rv = 1'b1;
                    end
                    r.total = valid_cnt;
                    r.uniq = unique_cnt;
                    r.ovf = sat_seen;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic offer_word(logic [1:0] f, logic [11:0] s, logic ok,
                              logic typed = 1'b0, t_rms_result typed_res = '0);
        int gap;
        t_rms_result r;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_sample <= s;
        i_sample_valid <= ok;
        do @(posedge i_clk); while (o_stall);
        if (window_step(f, s, ok, r)) pending_rms.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_rms.size() != 0) @(posedge i_clk);
        // an ignored word may still be in flight behind the last result
        repeat (200) @(posedge i_clk);
    endtask

    // receiver: random stall per result, plus long hold-offs on request
    initial begin
        int wait_cnt;
        int hold_cnt;
        wait_cnt = 0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) wait_cnt = no_idle ? 0 : $urandom_range(0, 7);
            if (hold_req > 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                i_stall <= 1'b1;
                hold_cnt--;
            end else if (wait_cnt > 0) begin
                i_stall <= 1'b1;
                wait_cnt--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_rms_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rms.size() == 0) begin
                $error("result with nothing expected: rms %0d", o_rms_value);
                errors++;
            end else begin
                e = pending_rms.pop_front();
                if (o_rms_value !== e.rms) begin
                    $error("rms_value expected %0d got %0d", e.rms, o_rms_value);
                    errors++;
                end
                if (o_result_valid !== e.rv) begin
                    $error("result_valid expected %0d got %0d", e.rv, o_result_valid);
                    errors++;
                end
                if (o_total_samples !== e.total) begin
                    $error("total_samples expected %0d got %0d", e.total, o_total_samples);
                    errors++;
                end
                if (o_unique_samples !== e.uniq) begin
                    $error("unique_samples expected %0d got %0d", e.uniq, o_unique_samples);
                    errors++;
                end
                if (o_overflow !== e.ovf) begin
                    $error("overflow expected %0d got %0d", e.ovf, o_overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        int sent;
        int len;
        logic [11:0] code;
        logic [11:0] prev;
        last_code = '0;
        last_held = 1'b0;
        window_open = 1'b0;
        valid_cnt = '0;
        unique_cnt = '0;
        code_sum = '0;
        square_sum = '0;
        sat_seen = 1'b0;

        dir_tab = '{
            '{acrms_pkg::FUNC_END,    12'd0,    1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd100,  1'b1, 1'b0, '0},
            '{FUNC_UNUSED,            12'd4095, 1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_START,  12'd4095, 1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd0,    1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd4095, 1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_END,    12'd0,    1'b1, 1'b1,
              '{20'd524160, 1'b1, 24'd2, 24'd2, 1'b0}},
            '{acrms_pkg::FUNC_START,  12'd0,    1'b0, 1'b0, '0},
            '{acrms_pkg::FUNC_END,    12'd0,    1'b1, 1'b1,
              '{20'd0, 1'b0, 24'd0, 24'd0, 1'b0}},
            '{acrms_pkg::FUNC_START,  12'd0,    1'b0, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd0,    1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd0,    1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd2730, 1'b0, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd1365, 1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_START,  12'd7,    1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd7,    1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd4095, 1'b0, 1'b0, '0},
            '{acrms_pkg::FUNC_END,    12'd0,    1'b0, 1'b1,
              '{20'd0, 1'b0, 24'd1, 24'd0, 1'b0}},
            '{acrms_pkg::FUNC_START,  12'd2048, 1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd1,    1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd4094, 1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_SAMPLE, 12'd2048, 1'b1, 1'b0, '0},
            '{acrms_pkg::FUNC_END,    12'd0,    1'b1, 1'b0, '0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            offer_word(dir_tab[i].func, dir_tab[i].sample, dir_tab[i].ok,
                       dir_tab[i].typed, dir_tab[i].res);

        sent = 0;
        while (sent < 450) begin
            // hold the output for a long stretch while words keep coming
            if (sent >= 120 && sent < 130) hold_req = 600;
            no_idle = (sent >= 250 && sent < 320);
            if ($urandom_range(0, 9) == 0) begin
                // stray word: sample or end, possibly outside a window, or unused code
                case ($urandom_range(0, 2))
                    0: offer_word(acrms_pkg::FUNC_SAMPLE, 12'($urandom), 1'($urandom));
                    1: offer_word(acrms_pkg::FUNC_END, 12'($urandom), 1'($urandom));
                    default: offer_word(FUNC_UNUSED, 12'($urandom), 1'($urandom));
                endcase
                sent++;
                // the stray sample/end is ignored only with the window closed
                if (window_open) begin
                    offer_word(acrms_pkg::FUNC_END, '0, 1'b1);
                    sent++;
                end
                continue;
            end
            prev = 12'($urandom);
            offer_word(acrms_pkg::FUNC_START, prev, $urandom_range(0, 7) != 0);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 3))
                    0: code = prev;
                    1: code = prev + 12'($urandom_range(0, 3)) - 12'd1;
                    default: code = 12'($urandom);
                endcase
                offer_word(acrms_pkg::FUNC_SAMPLE, code, $urandom_range(0, 9) != 0);
                prev = code;
                sent++;
            end
            if ($urandom_range(0, 9) == 0) begin
                sent++;
                continue;  // broken window: next start restarts it
            end
            offer_word(acrms_pkg::FUNC_END, 12'($urandom), 1'($urandom));
            sent += 2;
            if (sent >= 350 && sent < 375) drain_results();
        end

        drain_results();
        if (errors == 0 && pending_rms.size() == 0) begin
            $display("tb_ac_rms_window_accumulator passed");
        end else begin
            $display("tb_ac_rms_window_accumulator failed");
        end
        $finish;
    end
endmodule

[files.f]
rtl/acrms_pkg.sv
rtl/acrms_front.sv
rtl/acrms_back.sv
rtl/ac_rms_window_accumulator.sv
rtl/acrms_checker.sv
verif/tb_ac_rms_window_accumulator.sv
